>>> rtl/bma_pkg.sv
// Shared constants, register codes and sample helpers for the boxcar moving average.
package bma_pkg;

  // Default window depth and register reset values
  localparam int unsigned MAX_WINDOW_DEF = 16;
  localparam int unsigned WIN_LEN_W      = 5;
  localparam int unsigned KIND_W         = 3;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 5;
  localparam int unsigned SAMPLE_W       = 32;
  localparam int unsigned EXT_W          = SAMPLE_W + 1;

  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RST = 5'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND    = 1'b1;

  // Sample kinds
  localparam logic [KIND_W-1:0] KIND_S8  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_S16 = 3'd1;
  localparam logic [KIND_W-1:0] KIND_S32 = 3'd2;
  localparam logic [KIND_W-1:0] KIND_U8  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_U16 = 3'd4;
  localparam logic [KIND_W-1:0] KIND_U32 = 3'd5;

  localparam logic [KIND_W-1:0] KIND_RST = KIND_S32;

  // Extend the low bits of a raw sample to a signed 33-bit value
  function automatic logic signed [EXT_W-1:0] ext_sample(logic [SAMPLE_W-1:0] raw,
                                                        logic [KIND_W-1:0] kind);
    logic signed [EXT_W-1:0] v;
    unique case (kind)
      KIND_S8:  v = {{25{raw[7]}}, raw[7:0]};
      KIND_S16: v = {{17{raw[15]}}, raw[15:0]};
      KIND_S32: v = {raw[31], raw};
      KIND_U8:  v = {25'd0, raw[7:0]};
      KIND_U16: v = {17'd0, raw[15:0]};
      default:  v = {1'b0, raw};
    endcase
    return v;
  endfunction

  // Keep only the bits of the selected sample width
  function automatic logic [SAMPLE_W-1:0] fmt_avg(logic [SAMPLE_W-1:0] q,
                                                  logic [KIND_W-1:0] kind);
    logic [SAMPLE_W-1:0] v;
    unique case (kind)
      KIND_S8, KIND_U8:   v = {24'd0, q[7:0]};
      KIND_S16, KIND_U16: v = {16'd0, q[15:0]};
      default:            v = q;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/bma_div.sv
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module bma_div
  import bma_pkg::*;
#(
  parameter int unsigned NUM_W = 37,
  parameter int unsigned DEN_W = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] dividend_i,
  input  logic [DEN_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic [NUM_W-1:0]        quotient_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic             neg_q, neg_d;
  logic             done_q, done_d;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  // Trial subtract of the divisor from the shifted partial remainder
  assign rem_sh  = {rem_q, quo_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = rem_sh >= {1'b0, den_q};

  // Sequence magnitude load, bit iterations and sign fix
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          quo_d   = dividend_i[NUM_W-1] ? NUM_W'(-dividend_i) : NUM_W'(dividend_i);
          neg_d   = dividend_i[NUM_W-1];
          den_d   = divisor_i;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        quo_d = {quo_q[NUM_W-2:0], fits};
        rem_d = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        if (neg_q) begin
          quo_d = -quo_q;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Hold datapath
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/boxcar_moving_average.sv
// Boxcar moving average: keeps the last window_length samples and returns their
// mean, truncated toward zero, for each sample transaction. One transaction is
// taken at a time: a sample that refills the window (the first after reset or
// after any register write) sweeps the sample into all window_length slots,
// other samples read, subtract and add to swap the oldest entry out of the
// running sum; then the serial divider forms the mean. The next sample is
// taken after the result is loaded into the output register, which waits
// for any previous result to be taken. The running sum and fill share one
// adder; the window store is a single-port memory with registered read.
module boxcar_moving_average
  import bma_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SAMPLE_W-1:0]   average_o
);

  localparam int unsigned LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SUM_W  = EXT_W + $clog2(MAX_WINDOW);
  localparam int unsigned CMP_W  = (LEN_W > WIN_LEN_W) ? LEN_W : WIN_LEN_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FILL  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_SUB   = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_DIVGO = 3'd5;
  localparam logic [2:0] ST_WAIT  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0]              state_q, state_d;
  logic [WIN_LEN_W-1:0]    win_len_q;
  logic [KIND_W-1:0]       kind_q;
  logic                    filled_q, filled_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [LEN_W-1:0]        fill_q, fill_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [EXT_W-1:0] sample_q;
  logic signed [EXT_W-1:0] rd_q;
  logic                    out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]     out_q;

  logic signed [EXT_W-1:0] mem [MAX_WINDOW];

  logic [CMP_W-1:0]        len_raw;
  logic [LEN_W-1:0]        eff_len;
  logic                    in_fire;
  logic                    out_load;
  logic signed [SUM_W-1:0] add_b;
  logic signed [SUM_W-1:0] add_res;
  logic [LEN_W-1:0]        slot_inc;
  logic                    mem_we;
  logic [SLOT_W-1:0]       mem_addr;
  logic                    div_start;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quo;

  // Clamp the window length into 1..MAX_WINDOW
  always_comb begin
    len_raw = CMP_W'(win_len_q);
    if (len_raw == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_raw > CMP_W'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(len_raw);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign div_start  = (state_q == ST_DIVGO);

  // Shared adder: subtract the oldest sample, otherwise add the new one
  assign add_b   = (state_q == ST_SUB) ? SUM_W'(rd_q) : SUM_W'(sample_q);
  assign add_res = (state_q == ST_SUB) ? sum_q - add_b : sum_q + add_b;

  assign slot_inc = LEN_W'(slot_q) + LEN_W'(1);

  // Store writes: fill sweep, then the replaced slot
  assign mem_we   = (state_q == ST_FILL) || (state_q == ST_SUB);
  assign mem_addr = (state_q == ST_FILL) ? fill_q[SLOT_W-1:0] : slot_q;

  // Sequence one sample through fill or replace, divide and output
  always_comb begin
    state_d     = state_q;
    filled_d    = filled_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!filled_q) begin
            sum_d   = '0;
            fill_d  = '0;
            state_d = ST_FILL;
          end else begin
            if (LEN_W'(slot_q) >= eff_len) begin
              slot_d = '0;
            end
            state_d = ST_READ;
          end
        end
      end
      ST_FILL: begin
        sum_d  = add_res;
        fill_d = fill_q + LEN_W'(1);
        if (fill_q == eff_len - LEN_W'(1)) begin
          filled_d = 1'b1;
          slot_d   = '0;
          state_d  = ST_DIVGO;
        end
      end
      ST_READ: state_d = ST_SUB;
      ST_SUB: begin
        sum_d   = add_res;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        sum_d   = add_res;
        slot_d  = (slot_inc == eff_len) ? '0 : slot_inc[SLOT_W-1:0];
        state_d = ST_DIVGO;
      end
      ST_DIVGO: state_d = ST_WAIT;
      ST_WAIT: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // Register writes restart the window
    if (cfg_we_i) begin
      filled_d = 1'b0;
      slot_d   = '0;
      sum_d    = '0;
    end
  end

  // Hold control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_len_q   <= WIN_LEN_RST;
      kind_q      <= KIND_RST;
      filled_q    <= 1'b0;
      slot_q      <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filled_q    <= filled_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WIN_LEN: win_len_q <= cfg_data_i[WIN_LEN_W-1:0];
          CFG_KIND:    kind_q    <= cfg_data_i[KIND_W-1:0];
          default:     ;
        endcase
      end
    end
  end

  // Capture the sample and the formatted result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= ext_sample(sample_i, kind_q);
    end
    if (out_load) begin
      out_q <= fmt_avg(div_quo[SAMPLE_W-1:0], kind_q);
    end
  end

  // Window store with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= sample_q;
    end
    if (state_q == ST_READ) begin
      rd_q <= mem[slot_q];
    end
  end

  bma_div #(
    .NUM_W(SUM_W),
    .DEN_W(LEN_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (eff_len),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign average_o   = out_q;

  // The replace slot stays inside the window while the store is in use
  a_slot_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filled_q && (state_q == ST_IDLE)) |-> (LEN_W'(slot_q) < eff_len))
    else $error("write slot outside window");

  // A new result only comes from the output step
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result raised outside output step");

  // The divider finishes only while the sequencer waits for it
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WAIT))
    else $error("divider done outside wait");

  // A transaction on an empty window starts the fill sweep
  a_fill_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !filled_q && !cfg_we_i) |=> (state_q == ST_FILL))
    else $error("fill not started");

endmodule
